[sv/sst_pkg.sv]
package sst_pkg;

  localparam int OFFSET_BITS_DEF   = 16;
  localparam int KEYWORD_CHARS_DEF = 6;
  localparam int NUM_KEYWORDS      = 14;

  localparam logic [5:0] K_DOT     = 6'd7;
  localparam logic [5:0] K_BANG    = 6'd13;
  localparam logic [5:0] K_EQUAL   = 6'd15;
  localparam logic [5:0] K_LESS    = 6'd17;
  localparam logic [5:0] K_GREATER = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd21;
  localparam logic [5:0] K_NUMBER  = 6'd22;
  localparam logic [5:0] K_IDENT   = 6'd23;
  localparam logic [5:0] K_KW_BASE = 6'd24;
  localparam logic [5:0] K_END     = 6'd38;
  localparam logic [5:0] K_ERRKIND = 6'd39;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_CHAR  = 2'd1;
  localparam logic [1:0] ERR_STR   = 2'd2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // one result token, fully formed
  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } tok_t;

  // up to three results per beat
  typedef struct packed {
    logic [1:0]    count;
    tok_t [2:0]    tok;
  } tok_group_t;

  // byte class from the front end
  typedef struct packed {
    logic is_end;
    logic [7:0] b;
    logic digit;
    logic alpha;
    logic space;
    logic newline;
    logic quote;
    logic hash;
    logic dot;
    logic equal;
    logic punct;
    logic [3:0] punct_idx;
    logic op;
    logic [5:0] op_kind;
  } byte_class_t;

  // keyword text, first char in low byte
  function automatic logic [63:0] kw_text(input int i);
    unique case (i)
      0: kw_text = {40'd0, "dna"};
      1: kw_text = {32'd0, "esle"};
      2: kw_text = {32'd0, "file"};
      3: kw_text = {24'd0, "eslaf"};
      4: kw_text = {40'd0, "rof"};
      5: kw_text = {48'd0, "nf"};
      6: kw_text = {48'd0, "fi"};
      7: kw_text = {40'd0, "lin"};
      8: kw_text = {48'd0, "ro"};
      9: kw_text = {40'd0, "yas"};
      10: kw_text = {16'd0, "nruter"};
      11: kw_text = {32'd0, "eurt"};
      12: kw_text = {40'd0, "tel"};
      default: kw_text = {24'd0, "elihw"};
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    unique case (i)
      0, 4, 7, 9, 12: kw_len = 4'd3;
      1, 2, 11:       kw_len = 4'd4;
      3, 13:          kw_len = 4'd5;
      5, 6, 8:        kw_len = 4'd2;
      default:        kw_len = 4'd6;
    endcase
  endfunction

endpackage

[sv/sst_classify.sv]
module sst_classify (
  input  logic                     cmd_end,
  input  logic [7:0]               b,
  output sst_pkg::byte_class_t     cls
);
  import sst_pkg::*;

  always_comb begin
    cls = '0;
    cls.is_end  = cmd_end;
    cls.b       = b;
    cls.digit   = (b >= "0") && (b <= "9");
    cls.alpha   = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
    cls.space   = (b == " ") || (b == 8'h0d) || (b == 8'h09);
    cls.newline = (b == 8'h0a);
    cls.quote   = (b == 8'h22);
    cls.hash    = (b == "#");
    cls.dot     = (b == ".");
    cls.equal   = (b == "=");
    cls.punct   = 1'b1;
    unique case (b)
      "(": cls.punct_idx = 4'd0;
      ")": cls.punct_idx = 4'd1;
      "{": cls.punct_idx = 4'd2;
      "}": cls.punct_idx = 4'd3;
      "[": cls.punct_idx = 4'd4;
      "]": cls.punct_idx = 4'd5;
      ",": cls.punct_idx = 4'd6;
      ".": cls.punct_idx = 4'd7;
      "-": cls.punct_idx = 4'd8;
      "+": cls.punct_idx = 4'd9;
      ";": cls.punct_idx = 4'd10;
      "*": cls.punct_idx = 4'd11;
      "/": cls.punct_idx = 4'd12;
      default: begin
        cls.punct_idx = 4'd0;
        cls.punct     = 1'b0;
      end
    endcase
    cls.op = 1'b1;
    unique case (b)
      "!": cls.op_kind = K_BANG;
      "=": cls.op_kind = K_EQUAL;
      "<": cls.op_kind = K_LESS;
      ">": cls.op_kind = K_GREATER;
      default: begin
        cls.op_kind = K_BANG;
        cls.op      = 1'b0;
      end
    endcase
  end

endmodule

[sv/sst_queue.sv]
module sst_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  // two-entry queue
  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;
  logic         wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

[sv/sst_scan.sv]
module sst_scan #(
  parameter int OFFSET_BITS   = sst_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = sst_pkg::KEYWORD_CHARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sst_pkg::byte_class_t  cls,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data,
  output logic                  grp_valid,
  input  logic                  grp_ready,
  output sst_pkg::tok_group_t   grp
);
  import sst_pkg::*;

  localparam int WLB = $clog2(KEYWORD_CHARS + 2);
  localparam int WIB = $clog2(KEYWORD_CHARS);
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_STRING, M_INT, M_DOTWAIT, M_FRAC, M_WORD, M_OP
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic [5:0]             pop_r, pop_nxt;
  logic [OFFSET_BITS-1:0] tb_r, tb_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [15:0]            line_r, line_nxt;
  logic [15:0]            sline_r;
  logic                   started_r, started_nxt;
  logic [7:0]             wbuf_r [KEYWORD_CHARS];
  logic [WLB-1:0]         wlen_r, wlen_nxt;
  logic                   wb_we;
  logic [WIB-1:0]         wb_idx;
  logic                   fire;
  tok_group_t             g;

  assign in_ready  = grp_ready;
  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;
  assign grp_valid = fire;
  assign grp       = g;

  function automatic logic [15:0] c16(input logic [OFFSET_BITS:0] v);
    logic [63:0] w;
    w   = 64'(v);
    c16 = (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [OFFSET_BITS:0] sub0(input logic [OFFSET_BITS:0] a,
                                                input logic [OFFSET_BITS:0] b);
    sub0 = (a > b) ? a - b : '0;
  endfunction

  // keyword compare over the stored word
  logic [5:0] wkind;
  always_comb begin
    logic        hit;
    logic [63:0] kt;
    wkind = K_IDENT;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      kt  = kw_text(i);
      hit = ({{(8-WLB){1'b0}}, wlen_r} == {4'd0, kw_len(i)});
      for (int j = 0; j < KEYWORD_CHARS; j++) begin
        if (j < 8 && j < int'(wlen_r) && wbuf_r[j] != kt[8*(j%8) +: 8]) hit = 1'b0;
      end
      if (hit) wkind = K_KW_BASE + 6'(i);
    end
  end

  always_comb begin
    logic [OFFSET_BITS:0] p, t, pm1;
    logic                 to_idle, do_flush, at_end;
    int                   n;
    tok_t                 tk;
    p   = {1'b0, pos_r};
    t   = {1'b0, tb_r};
    pm1 = sub0(p, (OFFSET_BITS + 1)'(1));
    g        = '0;
    n        = 0;
    mode_nxt = mode_r;
    pop_nxt  = pop_r;
    tb_nxt   = tb_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    started_nxt = started_r;
    wlen_nxt = wlen_r;
    wb_we    = 1'b0;
    wb_idx   = '0;
    to_idle  = 1'b0;
    do_flush = 1'b0;
    at_end   = cls.is_end;
    tk       = '0;

    if (cls.is_end) begin
      do_flush = 1'b1;
    end else begin
      unique case (mode_r)
        M_OP: begin
          if (cls.equal) begin
            tk = '{pop_r + 6'd1, ERR_NONE, c16(t), 16'd2, line_r, 1'b0};
            g.tok[n] = tk; n++;
            mode_nxt = M_IDLE;
          end else begin
            do_flush = 1'b1; to_idle = 1'b1;
          end
        end
        M_COMMENT: if (cls.newline) begin
          mode_nxt = M_IDLE;
          if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        end
        M_STRING: begin
          if (cls.quote) begin
            tk = '{K_STRING, ERR_NONE, c16(t), c16(sub0(p, t) + 1'b1), line_r, 1'b0};
            g.tok[n] = tk; n++;
            mode_nxt = M_IDLE;
          end else if (cls.newline && line_r != 16'hFFFF) begin
            line_nxt = line_r + 16'd1;
          end
        end
        M_INT: begin
          if (cls.dot) mode_nxt = M_DOTWAIT;
          else if (!cls.digit) begin do_flush = 1'b1; to_idle = 1'b1; end
        end
        M_DOTWAIT: begin
          if (cls.digit) mode_nxt = M_FRAC;
          else begin do_flush = 1'b1; to_idle = 1'b1; end
        end
        M_FRAC: if (!cls.digit) begin do_flush = 1'b1; to_idle = 1'b1; end
        M_WORD: begin
          if (cls.alpha || cls.digit) begin
            if (int'(wlen_r) < KEYWORD_CHARS) begin
              wb_we    = 1'b1;
              wb_idx   = wlen_r[WIB-1:0];
              wlen_nxt = wlen_r + 1'b1;
            end else begin
              wlen_nxt = WLB'(KEYWORD_CHARS + 1);
            end
          end else begin
            do_flush = 1'b1; to_idle = 1'b1;
          end
        end
        default: begin mode_nxt = M_IDLE; to_idle = 1'b1; end
      endcase
    end

    if (do_flush) begin
      unique case (mode_r)
        M_OP: begin
          g.tok[n] = '{pop_r, ERR_NONE, c16(t), 16'd1, line_r, 1'b0}; n++;
        end
        M_INT, M_FRAC: begin
          g.tok[n] = '{K_NUMBER, ERR_NONE, c16(t), c16(sub0(p, t)), line_r, 1'b0}; n++;
        end
        M_DOTWAIT: begin
          g.tok[n] = '{K_NUMBER, ERR_NONE, c16(t), c16(sub0(pm1, t)), line_r, 1'b0}; n++;
          g.tok[n] = '{K_DOT, ERR_NONE, c16(pm1), 16'd1, line_r, 1'b0}; n++;
        end
        M_WORD: begin
          g.tok[n] = '{(int'(wlen_r) > KEYWORD_CHARS) ? K_IDENT : wkind, ERR_NONE,
                       c16(t), c16(sub0(p, t)), line_r, 1'b0};
          n++;
        end
        M_STRING: if (at_end) begin
          g.tok[n] = '{K_ERRKIND, ERR_STR, c16(t), c16(sub0(p, t)), line_r, 1'b0}; n++;
        end
        default: ;
      endcase
      mode_nxt = M_IDLE;
    end

    if (cls.is_end) begin
      g.tok[n] = '{K_END, ERR_NONE, c16(p), 16'd0, line_r, 1'b0}; n++;
      mode_nxt = M_IDLE; pop_nxt = '0; tb_nxt = '0; pos_nxt = '0;
      line_nxt = sline_r; wlen_nxt = '0; started_nxt = 1'b0;
    end else begin
      started_nxt = 1'b1;
      if (to_idle) begin
        tb_nxt = pos_r;
        if (cls.punct) begin
          g.tok[n] = '{6'(cls.punct_idx), ERR_NONE, c16(p), 16'd1, line_r, 1'b0}; n++;
        end else if (cls.op) begin
          mode_nxt = M_OP; pop_nxt = cls.op_kind;
        end else if (cls.hash) mode_nxt = M_COMMENT;
        else if (cls.space) ;
        else if (cls.newline) begin
          if (line_r != 16'hFFFF) line_nxt = line_r + 16'd1;
        end else if (cls.quote) mode_nxt = M_STRING;
        else if (cls.digit) mode_nxt = M_INT;
        else if (cls.alpha) begin
          mode_nxt = M_WORD; wb_we = 1'b1; wb_idx = '0; wlen_nxt = WLB'(1);
        end else begin
          g.tok[n] = '{K_ERRKIND, ERR_CHAR, c16(p), 16'd1, line_r, 1'b0}; n++;
        end
      end
      if (pos_r != OFF_MAX) pos_nxt = pos_r + 1'b1;
    end
    g.count = 2'(n);
    if (n > 0) g.tok[n-1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (fire && wb_we) wbuf_r[wb_idx] <= cls.b;
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      pop_r     <= '0;
      tb_r      <= '0;
      pos_r     <= '0;
      line_r    <= 16'd1;
      sline_r   <= 16'd1;
      started_r <= 1'b0;
      wlen_r    <= '0;
    end else begin
      if (fire) begin
        mode_r    <= mode_nxt;
        pop_r     <= pop_nxt;
        tb_r      <= tb_nxt;
        pos_r     <= pos_nxt;
        started_r <= started_nxt;
        wlen_r    <= wlen_nxt;
      end
      if (fire) line_r <= line_nxt;
      else if (cfg_valid && !started_r) line_r <= cfg_data;
      if (cfg_valid) sline_r <= cfg_data;
    end
  end

endmodule

[sv/sst_emit.sv]
module sst_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 grp_valid,
  output logic                 grp_ready,
  input  sst_pkg::tok_group_t  grp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sst_pkg::tok_t        tok
);
  import sst_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       have;

  assign have      = grp_valid && (grp.count != 2'd0);
  assign out_valid = have;
  assign tok       = grp.tok[idx_r];
  assign grp_ready = !have || (out_ready && (idx_r + 2'd1 == grp.count));

  always_comb begin
    idx_nxt = idx_r;
    if (grp_valid && grp_ready) idx_nxt = 2'd0;
    else if (have && out_ready) idx_nxt = idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[sv/script_source_tokenizer.sv]
// Path: a byte enters the scanner at acceptance; its tokens are registered in the queue
// before they leave. Throughput: one byte per cycle while each byte yields at most one token
// and out_tready is high; a byte that yields more tokens sends one token per beat on out_.
// Reset (rst_n low, synchronous): scanner idle, offset 0, line 1, start_line 1,
// queue empty.
module script_source_tokenizer #(
  parameter int OFFSET_BITS   = sst_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_CHARS = sst_pkg::KEYWORD_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tuser,   // [0] command
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,   // start_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [5:0] kind [21:6] start [37:22] length [53:38] line
  output logic [1:0]  out_tuser,  // [1:0] error_code
  output logic        out_tlast
);
  import sst_pkg::*;

  localparam int GW = $bits(tok_group_t);

  byte_class_t cls;
  logic        sc_valid, sc_ready;
  tok_group_t  sc_grp, q_grp;
  logic        q_valid, q_ready;
  tok_t        tk;

  // front: byte classification
  sst_classify u_cls (
    .cmd_end (in_tuser),
    .b       (in_tdata),
    .cls     (cls)
  );

  // scanner state machine; emits a group of 0..3 tokens per beat
  sst_scan #(
    .OFFSET_BITS   (OFFSET_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cls       (cls),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .grp_valid (sc_valid),
    .grp_ready (sc_ready),
    .grp       (sc_grp)
  );

  // decoupling queue between scanner and token serializer
  sst_queue #(.W(GW)) u_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (sc_valid),
    .wr_ready (sc_ready),
    .wr_data  (sc_grp),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_grp)
  );

  // back: one token per beat
  sst_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (q_valid),
    .grp_ready (q_ready),
    .grp       (q_grp),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .tok       (tk)
  );

  assign out_tdata = {2'b00, tk.line, tk.len, tk.start, tk.kind};
  assign out_tuser = tk.err;
  assign out_tlast = tk.last;

endmodule
